### src/calendar_hour_offset_macros.svh
// ----------------------------------------------------------------------------
// Calendar hour offset: assertion macros
// Concurrent assertion wrappers. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_HOUR_OFFSET_MACROS_SVH
`define CALENDAR_HOUR_OFFSET_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define CALHR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar_hour_offset: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CALHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar_hour_offset: assertion failed");

`else

`define CALHR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CALHR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/calhr_pkg.sv
// ----------------------------------------------------------------------------
// Calendar hour offset package
// Shared widths, calendar constants, pipeline item types and month length.
// ----------------------------------------------------------------------------
`default_nettype none

package calhr_pkg;

    localparam int YEAR_WIDTH = 16;

    // Reciprocal of 25 for the year divisibility test: floor(y * RECIP >> SHIFT)
    // equals floor(y / 25) for every year of YEAR_WIDTH bits.
    localparam int RECIP_SHIFT = YEAR_WIDTH + 5;
    localparam int RECIP_WIDTH = YEAR_WIDTH + 1;
    localparam int PROD_WIDTH  = YEAR_WIDTH + RECIP_WIDTH;
    localparam int Q_WIDTH     = PROD_WIDTH - RECIP_SHIFT;
    localparam logic [RECIP_WIDTH-1:0] RECIP = RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25);
    localparam logic [4:0] DIV_CENTURY_FACTOR = 5'd25;

    localparam logic signed [5:0] OFFSET_MAX   = 6'sd23;
    localparam logic signed [5:0] OFFSET_RESET = 6'sd9;

    localparam logic signed [6:0] HOURS_PER_DAY_S = 7'sd24;
    localparam logic signed [6:0] HOURS_TWO_DAYS_S = 7'sd48;
    localparam logic [4:0] HOURS_PER_DAY = 5'd24;

    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_FEB   = 4'd2;
    localparam logic [3:0] MONTH_LAST  = 4'd12;
    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [4:0] DAYS_LONG   = 5'd31;
    localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Forward day steps still to apply.
    localparam logic [1:0] FWD_NONE = 2'd0;
    localparam logic [1:0] FWD_ONE  = 2'd1;
    localparam logic [1:0] FWD_TWO  = 2'd2;

    typedef struct packed {
        logic [YEAR_WIDTH-1:0] year;
        logic [3:0]            month;
        logic [4:0]            day;
        logic signed [6:0]     hour_sum;
        logic [Q_WIDTH-1:0]    quot;
    } calhr_split_t;

    typedef struct packed {
        logic [YEAR_WIDTH-1:0] year;
        logic [3:0]            month;
        logic [4:0]            day;
        logic [4:0]            hour;
        logic                  leap;
        logic [1:0]            fwd_cnt;
        logic                  back;
    } calhr_item_t;

    // Days in a month; months outside 1..12 count as 31 days.
    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        len = DAYS_LONG;
        if (month >= MONTH_FIRST && month <= MONTH_LAST) begin
            len = MONTH_LEN[month - MONTH_FIRST];
            if (month == MONTH_FEB && leap) begin
                len = DAYS_FEB_LEAP;
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

### src/calhr_split.sv
// ----------------------------------------------------------------------------
// Calendar hour offset: split stage
// Clamp the offset, add it to the hour and start the divide-by-25 of the year.
// ----------------------------------------------------------------------------
`default_nettype none

module calhr_split
    import calhr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [YEAR_WIDTH-1:0] in_year,
    input  wire logic [3:0]            in_month,
    input  wire logic [4:0]            in_day,
    input  wire logic [4:0]            in_hour,
    input  wire logic signed [5:0]     offset_hours,
    output logic                       out_valid,
    output calhr_split_t               out_item
);

    logic signed [5:0]     off_clamped;
    logic [PROD_WIDTH-1:0] prod;
    calhr_split_t          item_next;
    calhr_split_t          item_reg;
    logic                  valid_reg;

    always_comb
    begin
        off_clamped = offset_hours;
        if (offset_hours < -OFFSET_MAX) begin
            off_clamped = -OFFSET_MAX;
        end else if (offset_hours > OFFSET_MAX) begin
            off_clamped = OFFSET_MAX;
        end
    end

    assign prod = PROD_WIDTH'(in_year) * PROD_WIDTH'(RECIP);

    always_comb
    begin
        item_next.year     = in_year;
        item_next.month    = in_month;
        item_next.day      = in_day;
        item_next.hour_sum = $signed({2'b00, in_hour}) + $signed({off_clamped[5], off_clamped});
        item_next.quot     = prod[PROD_WIDTH-1:RECIP_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

### src/calhr_classify.sv
// ----------------------------------------------------------------------------
// Calendar hour offset: classify stage
// Resolve the leap flag and fold the hour sum into 0..23 with a day step count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_hour_offset_macros.svh"

module calhr_classify
    import calhr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         in_valid,
    input  wire calhr_split_t in_item,
    output logic              out_valid,
    output calhr_item_t       out_item
);

    logic [YEAR_WIDTH-1:0] rem25;
    logic [6:0]            hour_wrapped;
    calhr_item_t           item_next;
    calhr_item_t           item_reg;
    logic                  valid_reg;

    // Remainder of year / 25; zero means divisible by 25.
    assign rem25 = in_item.year
                   - (YEAR_WIDTH'(in_item.quot) * YEAR_WIDTH'(DIV_CENTURY_FACTOR));

    always_comb
    begin
        item_next.year    = in_item.year;
        item_next.month   = in_item.month;
        item_next.day     = in_item.day;
        // Divisible by 4, and not by 100 unless by 400 (400 = 16 * 25).
        item_next.leap    = (in_item.year[1:0] == 2'b00)
                            && ((rem25 != '0) || (in_item.year[3:0] == 4'b0000));
        item_next.fwd_cnt = FWD_NONE;
        item_next.back    = 1'b0;
        hour_wrapped      = 7'(in_item.hour_sum);
        if (in_item.hour_sum < 7'sd0) begin
            hour_wrapped   = 7'(in_item.hour_sum + HOURS_PER_DAY_S);
            item_next.back = 1'b1;
        end else if (in_item.hour_sum >= HOURS_TWO_DAYS_S) begin
            hour_wrapped      = 7'(in_item.hour_sum - HOURS_TWO_DAYS_S);
            item_next.fwd_cnt = FWD_TWO;
        end else if (in_item.hour_sum >= HOURS_PER_DAY_S) begin
            hour_wrapped      = 7'(in_item.hour_sum - HOURS_PER_DAY_S);
            item_next.fwd_cnt = FWD_ONE;
        end
        item_next.hour = hour_wrapped[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    `CALHR_ASSERT_SAME(a_classify_hour_range, clk, rst_n, out_valid, out_item.hour < HOURS_PER_DAY)
    `CALHR_ASSERT_SAME(a_classify_one_direction, clk, rst_n, out_valid && out_item.back, out_item.fwd_cnt == FWD_NONE)

endmodule

`default_nettype wire

### src/calhr_day_step.sv
// ----------------------------------------------------------------------------
// Calendar hour offset: day step stage
// Apply at most one day step, forward or backward, with month and year rollover.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_hour_offset_macros.svh"

module calhr_day_step
    import calhr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire calhr_item_t in_item,
    output logic             out_valid,
    output calhr_item_t      out_item
);

    logic [4:0]  cur_len;
    logic [3:0]  prev_month;
    calhr_item_t item_next;
    calhr_item_t item_reg;
    logic        valid_reg;

    assign cur_len = month_days(in_item.leap, in_item.month);

    always_comb
    begin
        item_next  = in_item;
        prev_month = MONTH_LAST;
        if (in_item.fwd_cnt != FWD_NONE) begin
            item_next.fwd_cnt = in_item.fwd_cnt - FWD_ONE;
            if ({1'b0, in_item.day} + 6'd1 > {1'b0, cur_len}) begin
                item_next.day = DAY_FIRST;
                if (in_item.month >= MONTH_LAST) begin
                    item_next.month = MONTH_FIRST;
                    item_next.year  = in_item.year + YEAR_WIDTH'(1);
                end else begin
                    item_next.month = in_item.month + 4'd1;
                end
            end else begin
                item_next.day = in_item.day + 5'd1;
            end
        end else if (in_item.back) begin
            item_next.back = 1'b0;
            if (in_item.day > DAY_FIRST) begin
                item_next.day = in_item.day - 5'd1;
            end else begin
                // Back to the last day of the previous month.
                if (in_item.month > MONTH_FIRST && in_item.month <= MONTH_LAST) begin
                    prev_month = in_item.month - 4'd1;
                end else if (in_item.month <= MONTH_FIRST) begin
                    item_next.year = in_item.year - YEAR_WIDTH'(1);
                end
                item_next.month = prev_month;
                item_next.day   = month_days(in_item.leap, prev_month);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    `CALHR_ASSERT_SAME(a_step_back_done, clk, rst_n, out_valid, !out_item.back)
    `CALHR_ASSERT_NEXT(a_step_hold, clk, rst_n, out_valid && !en, out_valid && $stable(out_item))

endmodule

`default_nettype wire

### src/calendar_hour_offset.sv
// ----------------------------------------------------------------------------
// Calendar hour offset
// Add a signed whole-hour offset to a Gregorian date and hour.
// ----------------------------------------------------------------------------
// Takes a date and hour (for example UTC) and returns it shifted by
// offset_hours, rolling the day, month and year forward or backward as
// needed, with 400/100/4 leap years and the year wrapping at 16 bits.
// Offsets beyond -23..+23 are clamped. The block is a four-stage pipeline:
// offset add and reciprocal multiply, leap/step classification, then two
// day-step stages (hours 25..31 at the input can need two forward days).
// It accepts one item per clock while out_ready stays high, and each result
// is registered in turn by each stage; the last stage is the output
// register, and a stall only holds the stages that are occupied, so empty
// stages keep taking items. Write offset_hours (cfg_we high) only while the
// pipeline is empty; it resets to +9.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_hour_offset_macros.svh"

module calendar_hour_offset
    import calhr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic signed [5:0]     offset_hours,
    // input items
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [YEAR_WIDTH-1:0] in_year,
    input  wire logic [3:0]            in_month,
    input  wire logic [4:0]            in_day,
    input  wire logic [4:0]            in_hour,
    // result items
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [YEAR_WIDTH-1:0]      out_year,
    output logic [3:0]                 out_month,
    output logic [4:0]                 out_day,
    output logic [4:0]                 out_hour
);

    logic signed [5:0] offset_hours_reg;

    logic         split_valid;
    calhr_split_t split_item;
    logic         class_valid;
    calhr_item_t  class_item;
    logic         step1_valid;
    calhr_item_t  step1_item;
    logic         step2_valid;
    calhr_item_t  step2_item;

    logic en_split;
    logic en_class;
    logic en_step1;
    logic en_step2;

    // Offset register; the user must write it only while the pipeline is empty, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            offset_hours_reg <= OFFSET_RESET;
        end else if (cfg_we) begin
            offset_hours_reg <= offset_hours;
        end
    end

    // Advance a stage when it is empty or its item moves on; bubbles collapse.
    assign en_step2 = !step2_valid || out_ready;
    assign en_step1 = !step1_valid || en_step2;
    assign en_class = !class_valid || en_step1;
    assign en_split = !split_valid || en_class;
    assign in_ready = en_split;

    // Stage 1: clamp and add the offset, multiply the year by 1/25.
    calhr_split u_split (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en_split),
        .in_valid     (in_valid),
        .in_year      (in_year),
        .in_month     (in_month),
        .in_day       (in_day),
        .in_hour      (in_hour),
        .offset_hours (offset_hours_reg),
        .out_valid    (split_valid),
        .out_item     (split_item)
    );

    // Stage 2: leap flag and number of day steps.
    calhr_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_class),
        .in_valid  (split_valid),
        .in_item   (split_item),
        .out_valid (class_valid),
        .out_item  (class_item)
    );

    // Stage 3: first day step (forward or backward).
    calhr_day_step u_step1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_step1),
        .in_valid  (class_valid),
        .in_item   (class_item),
        .out_valid (step1_valid),
        .out_item  (step1_item)
    );

    // Stage 4: second forward step, only for input hours past 23; output register.
    calhr_day_step u_step2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_step2),
        .in_valid  (step1_valid),
        .in_item   (step1_item),
        .out_valid (step2_valid),
        .out_item  (step2_item)
    );

    assign out_valid = step2_valid;
    assign out_year  = step2_item.year;
    assign out_month = step2_item.month;
    assign out_day   = step2_item.day;
    assign out_hour  = step2_item.hour;

    `CALHR_ASSERT_SAME(a_top_ready_when_empty, clk, rst_n, !out_valid, in_ready)
    `CALHR_ASSERT_SAME(a_top_steps_done, clk, rst_n, out_valid, step2_item.fwd_cnt == FWD_NONE)

endmodule

`default_nettype wire

### bench/tb_calendar_hour_offset.sv
// ----------------------------------------------------------------------------
// Calendar hour offset testbench
// Drives dates and hours through the block under a range of offsets and
// checks every adjusted date in order against a typed answer or a local calendar predictor.
// ----------------------------------------------------------------------------
// The run starts with a table of directed dates (leap days, century years,
// year wrap, out-of-range month, day and hour, offset clamping). Some rows
// carry a hand-worked answer; the others are checked against the predictor.
// Random phases follow, one per offset setting, with the offset written only
// while the pipeline is empty. Both handshakes idle at random; one phase
// holds the result side off for a long stretch so the pipeline backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_calendar_hour_offset;

    timeunit 1ns;
    timeprecision 1ps;

    import calhr_pkg::YEAR_WIDTH;
    import calhr_pkg::OFFSET_RESET;

    localparam int RESET_CYCLES  = 5;
    localparam int DRAIN_CYCLES  = 8;     // pipeline is four deep; extra wait after the drain
    localparam int HOLD_CYCLES   = 64;    // long result-side stall for back-pressure
    localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake before giving up
    localparam int MAX_GAP       = 5;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 90;
    localparam int REPORT_LIMIT  = 10;

    // One date and hour; the same shape serves input and result items.
    typedef struct packed {
        logic [YEAR_WIDTH-1:0] year;
        logic [3:0]            month;
        logic [4:0]            day;
        logic [4:0]            hour;
    } date_hour_t;

    // One row of the directed table.
    typedef struct packed {
        logic signed [5:0] offset;
        date_hour_t        stim;
        logic              known;
        date_hour_t        answer;
    } date_row_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic signed [5:0]     offset_hours = OFFSET_RESET;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [YEAR_WIDTH-1:0] in_year      = '0;
    logic [3:0]            in_month     = '0;
    logic [4:0]            in_day       = '0;
    logic [4:0]            in_hour      = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [YEAR_WIDTH-1:0] out_year;
    logic [3:0]            out_month;
    logic [4:0]            out_day;
    logic [4:0]            out_hour;

    date_hour_t        pending_dates [$];   // adjusted dates still owed by the block
    date_row_t         directed_rows [$];
    logic signed [5:0] active_offset = OFFSET_RESET;
    int                failures      = 0;
    bit                burst         = 1'b0;  // no idle cycles on either side
    bit                hold_output   = 1'b0;  // ask the result side for a long stall

    calendar_hour_offset dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .offset_hours (offset_hours),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_year      (in_year),
        .in_month     (in_month),
        .in_day       (in_day),
        .in_hour      (in_hour),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_year     (out_year),
        .out_month    (out_month),
        .out_day      (out_day),
        .out_hour     (out_hour)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------

    // Gregorian month length; months outside 1..12 count as 31 days.
    function automatic int days_in_month(int year, int month);
        bit is_leap;
        is_leap = (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
        case (month)
            2:             return is_leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Shift one date and hour by the given offset register value.
    function automatic date_hour_t shift_date_hour(date_hour_t stim,
                                                   logic signed [5:0] offset);
        date_hour_t adjusted;
        int         year_mask;
        int         y;
        int         m;
        int         d;
        int         h;
        int         off;
        year_mask = (1 << YEAR_WIDTH) - 1;
        y   = int'(stim.year);
        m   = int'(stim.month);
        d   = int'(stim.day);
        off = int'(offset);
        // Clamp the offset to one day either way.
        if (off < -23) off = -23;
        if (off > 23)  off = 23;
        h = int'(stim.hour) + off;
        // Hours 25..31 at the input can push two days forward.
        while (h >= 24) begin
            h -= 24;
            d++;
            if (d > days_in_month(y, m)) begin
                d = 1;
                m++;
                if (m > 12) begin
                    m = 1;
                    y = (y + 1) & year_mask;
                end
            end
        end
        // Step back one day; from day 0 or 1 go to the last day of the previous month.
        while (h < 0) begin
            h += 24;
            if (d > 1) begin
                d--;
            end
            else begin
                if (m > 1 && m <= 12) begin
                    m--;
                end
                else if (m > 12) begin
                    m = 12;
                end
                else begin
                    m = 12;
                    y = (y - 1) & year_mask;
                end
                d = days_in_month(y, m);
            end
        end
        adjusted.year  = y[YEAR_WIDTH-1:0];
        adjusted.month = m[3:0];
        adjusted.day   = d[4:0];
        adjusted.hour  = h[4:0];
        return adjusted;
    endfunction

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Count a failure; report only the first few in full.
    task automatic log_failure(string what);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $display("[%0t] FAIL: %s", $realtime, what);
        end
    endtask

    task automatic add_row(int off, int y, int m, int d, int h,
                           bit known, int ey, int em, int ed, int eh);
        date_row_t row;
        row.offset       = 6'(off);
        row.stim.year    = y[YEAR_WIDTH-1:0];
        row.stim.month   = m[3:0];
        row.stim.day     = d[4:0];
        row.stim.hour    = h[4:0];
        row.known        = known;
        row.answer.year  = ey[YEAR_WIDTH-1:0];
        row.answer.month = em[3:0];
        row.answer.day   = ed[4:0];
        row.answer.hour  = eh[4:0];
        directed_rows.push_back(row);
    endtask

    // Drain the pipeline, then write the offset register.
    task automatic set_offset(logic signed [5:0] value);
        in_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we       <= 1'b1;
        offset_hours <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        active_offset = value;
    endtask

    // Offer one item after a random gap and hold it until accepted. The
    // expected date is either the typed answer or the predictor's.
    task automatic send_date(date_hour_t stim, bit known, date_hour_t answer);
        int gap;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_year  <= stim.year;
        in_month <= stim.month;
        in_day   <= stim.day;
        in_hour  <= stim.hour;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_dates.push_back(known ? answer : shift_date_hour(stim, active_offset));
    endtask

    // Draw a date biased toward month ends, leap rules and year wrap.
    function automatic date_hour_t random_date();
        date_hour_t stim;
        int         y;
        int         m;
        int         d;
        int         len;
        case ($urandom_range(0, 5))
            0:       y = $urandom_range(0, 65535);
            1:       y = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                              : $urandom_range(65532, 65535);
            2:       y = 400 * $urandom_range(0, 163);
            3:       y = 100 * $urandom_range(0, 655);
            4:       y = 4 * $urandom_range(0, 16383);
            default: y = $urandom_range(1900, 2100);
        endcase
        m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
        len = days_in_month(y, m);
        case ($urandom_range(0, 9))
            0:       d = $urandom_range(0, 31);
            1, 2:    d = 1;
            3, 4:    d = len;
            5:       d = len - 1;
            default: d = $urandom_range(1, len);
        endcase
        stim.year  = y[YEAR_WIDTH-1:0];
        stim.month = m[3:0];
        stim.day   = d[4:0];
        stim.hour  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(0, 23));
        return stim;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random ready gaps, one long hold on request, and an
    // in-order check of every accepted result.
    // ------------------------------------------------------------------------
    initial begin : result_check
        int         gap;
        date_hour_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_output) begin
                // Hold ready low long enough for the pipeline to back up.
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_dates.size() == 0) begin
                log_failure($sformatf("result %0d-%0d-%0d h%0d with none expected",
                                      out_year, out_month, out_day, out_hour));
            end
            else begin
                want = pending_dates.pop_front();
                if (out_year !== want.year || out_month !== want.month ||
                    out_day !== want.day || out_hour !== want.hour) begin
                    log_failure($sformatf("expected %0d-%0d-%0d h%0d, got %0d-%0d-%0d h%0d",
                                          want.year, want.month, want.day, want.hour,
                                          out_year, out_month, out_day, out_hour));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up after a long stretch with no handshake on either side.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb_calendar_hour_offset NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        date_row_t         row;
        logic signed [5:0] phase_offset;
        int                p;
        int                n;

        // Directed table. The first rows run on the reset offset of +9.
        //      off  year   mo  dy  hr  known  answer
        add_row( 9,  2024,  3, 15, 10, 1,     2024,  3, 15, 19);
        add_row( 9,  2023, 12, 31, 20, 1,     2024,  1,  1,  5);  // new year
        add_row( 9,  2024,  2, 28, 15, 1,     2024,  2, 29,  0);  // leap day
        add_row( 9,  2023,  2, 28, 15, 1,     2023,  3,  1,  0);
        add_row( 9,  2100,  2, 28, 20, 1,     2100,  3,  1,  5);  // century, not leap
        add_row( 9,  2000,  2, 28, 20, 1,     2000,  2, 29,  5);  // 400-year leap
        add_row( 9, 65535, 12, 31, 23, 1,        0,  1,  1,  8);  // year wraps up
        add_row(23,  2024,  1, 31, 31, 1,     2024,  2,  2,  6);  // two forward days
        add_row(23,     0,  0,  0,  0, 1,        0,  0,  0, 23);
        add_row(23,  2024, 14, 31, 10, 0,        0,  0,  0,  0);  // month beyond 12
        add_row(23, 65535, 15, 31, 31, 0,        0,  0,  0,  0);
        add_row(31,  2024, 12, 31, 12, 1,     2025,  1,  1, 11);  // clamps to +23
        add_row(-23, 2024,  3,  1,  0, 1,     2024,  2, 29,  1);
        add_row(-23,    0,  1,  1,  5, 1,    65535, 12, 31,  6);  // year wraps down
        add_row(-23,  100,  0,  1,  0, 0,        0,  0,  0,  0);  // month zero back
        add_row(-23, 2024, 15,  0, 10, 0,        0,  0,  0,  0);  // day zero back
        add_row(-23, 2023,  1,  1, 23, 1,     2023,  1,  1,  0);
        add_row(-32, 2024,  1,  1,  0, 1,     2023, 12, 31,  1);  // clamps to -23
        add_row( 0,  2024, 13, 31,  5, 0,        0,  0,  0,  0);
        add_row( 0, 65535, 15, 31, 31, 0,        0,  0,  0,  0);
        add_row( 0,     0,  0,  0,  0, 1,        0,  0,  0,  0);
        add_row( 1,  2023,  2, 30, 23, 0,        0,  0,  0,  0);  // day past month end
        add_row(-1,  2024,  5,  0,  0, 0,        0,  0,  0,  0);
        add_row(-1,  2024,  3,  1,  0, 0,        0,  0,  0,  0);

        // Hold reset for RESET_CYCLES clocks, then release it once.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table; rewrite the offset only when a row asks for a new one.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.offset != active_offset) set_offset(row.offset);
            send_date(row.stim, row.known, row.answer);
        end

        // Random phases: offset extremes, clamped values, zero and +9, then random ones.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       phase_offset = -6'sd23;
                1:       phase_offset = 6'sd23;
                2:       phase_offset = -6'sd32;
                3:       phase_offset = 6'sd31;
                4:       phase_offset = 6'sd0;
                5:       phase_offset = OFFSET_RESET;
                default: phase_offset = 6'($urandom_range(0, 63));
            endcase
            set_offset(phase_offset);
            // Phase 2 backs up the pipeline and starts in burst; phase 4 runs with no idle cycles.
            if (p == 2) hold_output = 1'b1;
            burst = (p == 2 || p == 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 40) burst = 1'b0;
                send_date(random_date(), 1'b0, '0);
            end
            burst = 1'b0;
        end

        // Drain, then wait out DRAIN_CYCLES more to catch stray results.
        in_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_dates.size() != 0) begin
            log_failure($sformatf("%0d results never arrived", pending_dates.size()));
        end

        if (failures == 0) begin
            $display("tb_calendar_hour_offset OK");
        end
        else begin
            $display("tb_calendar_hour_offset NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

### calendar_hour_offset.f
+incdir+src
src/calhr_pkg.sv
src/calhr_split.sv
src/calhr_classify.sv
src/calhr_day_step.sv
src/calendar_hour_offset.sv
bench/tb_calendar_hour_offset.sv
